// ===== rtl/core/dmxu_pkg.sv =====
// Shared types, widths and operation codes for the DMX universe store.
package dmxu_pkg;

    localparam int SLOTS_DEFAULT = 512;

    // Field widths of the command and result items.
    localparam int OP_W    = 3;
    localparam int SLOT_W  = 9;
    localparam int VALUE_W = 8;
    localparam int COUNT_W = 10;
    localparam int LEN_W   = 10;

    // Working width for offsets, range ends and lengths: holds 4096 and 511 + 1023.
    localparam int CALC_W = 14;

    localparam logic [OP_W-1:0] OP_SET_SLOT  = 3'd0;
    localparam logic [OP_W-1:0] OP_FILL      = 3'd1;
    localparam logic [OP_W-1:0] OP_MERGE     = 3'd2;
    localparam logic [OP_W-1:0] OP_LOAD      = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_SLOT = 3'd4;
    localparam logic [OP_W-1:0] OP_LENGTH    = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_RMW,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

// ===== rtl/core/dmxu_if.sv =====
// Valid/ready channel interfaces for command and result items.
interface dmxu_in_if;
    logic                          valid;
    logic                          ready;
    logic [dmxu_pkg::OP_W-1:0]     op;
    logic [dmxu_pkg::SLOT_W-1:0]   slot;
    logic [dmxu_pkg::VALUE_W-1:0]  value;
    logic [dmxu_pkg::COUNT_W-1:0]  count;
    logic                          last;
    logic                          zero_all;

    modport source (output valid, op, slot, value, count, last, zero_all, input ready);
    modport sink   (input valid, op, slot, value, count, last, zero_all, output ready);
endinterface

interface dmxu_out_if;
    logic                          valid;
    logic                          ready;
    logic [dmxu_pkg::VALUE_W-1:0]  read_value;
    logic                          accepted;
    logic [dmxu_pkg::LEN_W-1:0]    valid_length;

    modport source (output valid, read_value, accepted, valid_length, input ready);
    modport sink   (input valid, read_value, accepted, valid_length, output ready);
endinterface

// ===== rtl/core/dmxu_mem.sv =====
// Single-port slot memory with a registered read.
module dmxu_mem #(
    parameter int SLOTS = dmxu_pkg::SLOTS_DEFAULT,
    parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                          clk,
    input  dmxu_pkg::mem_ctl_t            ctl,
    input  logic [AW-1:0]                 addr,
    input  logic [dmxu_pkg::VALUE_W-1:0]  wdata,
    output logic [dmxu_pkg::VALUE_W-1:0]  rdata
);

    logic [dmxu_pkg::VALUE_W-1:0] slot_mem [SLOTS];
    logic [dmxu_pkg::VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            slot_mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= slot_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/dmxu_ctrl.sv =====
// Command decode, sweep and read-modify-write sequencer, length state and result register.
module dmxu_ctrl #(
    parameter int SLOTS = dmxu_pkg::SLOTS_DEFAULT,
    parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    dmxu_in_if.sink                       cmd,
    dmxu_out_if.source                    result,
    output dmxu_pkg::mem_ctl_t            mem_ctl,
    output logic [AW-1:0]                 mem_addr,
    output logic [dmxu_pkg::VALUE_W-1:0]  mem_wdata,
    input  logic [dmxu_pkg::VALUE_W-1:0]  mem_rdata
);

    localparam int CW = dmxu_pkg::CALC_W;
    localparam int LW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_W = CW'(SLOTS);

    dmxu_pkg::state_t state_reg, state_next;

    logic [LW-1:0] len_reg, len_next;
    logic          alloc_reg, alloc_next;
    logic          out_valid_reg, out_valid_next;

    logic [CW-1:0]                addr_reg, addr_next;
    logic [CW-1:0]                stop_reg, stop_next;
    logic [CW-1:0]                wlo_reg, wlo_next;
    logic [CW-1:0]                whi_reg, whi_next;
    logic [dmxu_pkg::VALUE_W-1:0] val_reg, val_next;
    logic                         merge_reg, merge_next;
    logic                         ok_reg, ok_next;
    logic                         below_reg, below_next;
    logic                         acc_reg, acc_next;
    logic [dmxu_pkg::VALUE_W-1:0] rdv_reg, rdv_next;
    logic [dmxu_pkg::VALUE_W-1:0] out_rdv_reg, out_rdv_next;
    logic                         out_acc_reg, out_acc_next;
    logic [dmxu_pkg::LEN_W-1:0]   out_len_reg, out_len_next;

    logic          accept;
    logic          out_load;
    logic          sweep_end;
    logic          in_window;
    logic [CW-1:0] addr_inc;

    logic [CW-1:0] slot_w, count_w, len_w, eff_len, slot_1, slot_1c, room, fill_n, fill_end;
    logic          slot_ok;

    logic [CW-1:0] dec_start, dec_stop, dec_wlo, dec_whi, dec_len;
    logic          dec_acc, dec_alloc, dec_rmw, dec_merge, dec_ok, dec_below;

    assign accept    = cmd.valid && (state_reg == dmxu_pkg::ST_IDLE);
    assign out_load  = (state_reg == dmxu_pkg::ST_DONE) && (!out_valid_reg || result.ready);
    assign addr_inc  = addr_reg + CW'(1);
    assign sweep_end = (addr_inc == stop_reg);
    assign in_window = (addr_reg >= wlo_reg) && (addr_reg < whi_reg);

    assign slot_w   = CW'(cmd.slot);
    assign count_w  = CW'(cmd.count);
    assign len_w    = CW'(len_reg);
    assign eff_len  = alloc_reg ? len_w : '0;
    assign slot_ok  = slot_w < SLOTS_W;
    assign slot_1   = slot_w + CW'(1);
    assign slot_1c  = (slot_1 > SLOTS_W) ? SLOTS_W : slot_1;
    assign room     = SLOTS_W - slot_w;
    assign fill_n   = (count_w < room) ? count_w : room;
    assign fill_end = slot_w + fill_n;

    // Decode of the item at the input. For set_slot and fill, a store that is not yet allocated is
    // blacked out by a sweep over all slots, with the written range folded into the same sweep.
    always_comb
    begin
        dec_start = '0;
        dec_stop  = '0;
        dec_wlo   = '0;
        dec_whi   = '0;
        dec_len   = len_w;
        dec_acc   = 1'b1;
        dec_alloc = alloc_reg;
        dec_rmw   = 1'b0;
        dec_merge = 1'b0;
        dec_ok    = 1'b0;
        dec_below = 1'b0;
        case (cmd.op)
            dmxu_pkg::OP_SET_SLOT,
            dmxu_pkg::OP_FILL:
            begin
                if (!slot_ok)
                begin
                    dec_acc = 1'b0;
                end
                else if (!alloc_reg)
                begin
                    dec_stop  = SLOTS_W;
                    dec_wlo   = slot_w;
                    dec_whi   = (cmd.op == dmxu_pkg::OP_FILL) ? fill_end : slot_1;
                    dec_len   = SLOTS_W;
                    dec_alloc = 1'b1;
                end
                else if (slot_w > len_w)
                begin
                    dec_acc = 1'b0;
                end
                else
                begin
                    dec_start = slot_w;
                    dec_stop  = (cmd.op == dmxu_pkg::OP_FILL) ? fill_end : slot_1;
                    dec_wlo   = dec_start;
                    dec_whi   = dec_stop;
                    dec_len   = (dec_stop > len_w) ? dec_stop : len_w;
                end
            end
            dmxu_pkg::OP_MERGE:
            begin
                dec_alloc = 1'b1;
                dec_rmw   = 1'b1;
                dec_merge = 1'b1;
                dec_ok    = slot_ok;
                dec_below = slot_w < eff_len;
                if (cmd.last)
                begin
                    dec_len = (slot_1c > eff_len) ? slot_1c : eff_len;
                end
                else
                begin
                    dec_len = eff_len;
                end
            end
            dmxu_pkg::OP_LOAD:
            begin
                dec_alloc = 1'b1;
                dec_len   = cmd.last ? slot_1c : eff_len;
                if (slot_ok)
                begin
                    dec_start = slot_w;
                    dec_stop  = slot_1;
                    dec_wlo   = slot_w;
                    dec_whi   = slot_1;
                end
            end
            dmxu_pkg::OP_READ_SLOT:
            begin
                dec_rmw = 1'b1;
                dec_ok  = alloc_reg && slot_ok && (slot_w < len_w);
            end
            dmxu_pkg::OP_LENGTH:
            begin
                if (cmd.zero_all)
                begin
                    dec_stop  = SLOTS_W;
                    dec_len   = SLOTS_W;
                    dec_alloc = 1'b1;
                end
                else
                begin
                    dec_len = '0;
                end
            end
            default:
            begin
                dec_acc = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dmxu_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (dec_rmw)
                    begin
                        state_next = dmxu_pkg::ST_RMW;
                    end
                    else if (dec_stop != dec_start)
                    begin
                        state_next = dmxu_pkg::ST_SWEEP;
                    end
                    else
                    begin
                        state_next = dmxu_pkg::ST_DONE;
                    end
                end
            end
            dmxu_pkg::ST_SWEEP:
            begin
                if (sweep_end)
                begin
                    state_next = dmxu_pkg::ST_DONE;
                end
            end
            dmxu_pkg::ST_RMW:
            begin
                state_next = dmxu_pkg::ST_DONE;
            end
            dmxu_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = dmxu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmxu_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory port and handshake outputs.
    always_comb
    begin
        mem_ctl   = '0;
        mem_addr  = addr_reg[AW-1:0];
        mem_wdata = val_reg;
        cmd.ready = 1'b0;
        case (state_reg)
            dmxu_pkg::ST_IDLE:
            begin
                cmd.ready     = 1'b1;
                mem_addr      = slot_w[AW-1:0];
                mem_ctl.rd_en = cmd.valid && dec_rmw;
            end
            dmxu_pkg::ST_SWEEP:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_wdata     = in_window ? val_reg : '0;
            end
            dmxu_pkg::ST_RMW:
            begin
                // Highest takes precedence below the old length; past it the byte is copied.
                mem_ctl.wr_en = merge_reg && ok_reg && (!below_reg || (val_reg > mem_rdata));
            end
            default:
            begin
                mem_ctl = '0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        len_next       = len_reg;
        alloc_next     = alloc_reg;
        addr_next      = addr_reg;
        stop_next      = stop_reg;
        wlo_next       = wlo_reg;
        whi_next       = whi_reg;
        val_next       = val_reg;
        merge_next     = merge_reg;
        ok_next        = ok_reg;
        below_next     = below_reg;
        acc_next       = acc_reg;
        rdv_next       = rdv_reg;
        out_rdv_next   = out_rdv_reg;
        out_acc_next   = out_acc_reg;
        out_len_next   = out_len_reg;
        out_valid_next = out_valid_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            len_next   = LW'(dec_len);
            alloc_next = dec_alloc;
            addr_next  = dec_rmw ? slot_w : dec_start;
            stop_next  = dec_stop;
            wlo_next   = dec_wlo;
            whi_next   = dec_whi;
            val_next   = cmd.value;
            merge_next = dec_merge;
            ok_next    = dec_ok;
            below_next = dec_below;
            acc_next   = dec_acc;
            rdv_next   = '0;
        end

        if (state_reg == dmxu_pkg::ST_SWEEP)
        begin
            addr_next = addr_inc;
        end

        if (state_reg == dmxu_pkg::ST_RMW)
        begin
            rdv_next = (!merge_reg && ok_reg) ? mem_rdata : '0;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_rdv_next   = rdv_reg;
            out_acc_next   = acc_reg;
            out_len_next   = len_w[dmxu_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmxu_pkg::ST_IDLE;
            len_reg       <= '0;
            alloc_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            alloc_reg     <= alloc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        stop_reg    <= stop_next;
        wlo_reg     <= wlo_next;
        whi_reg     <= whi_next;
        val_reg     <= val_next;
        merge_reg   <= merge_next;
        ok_reg      <= ok_next;
        below_reg   <= below_next;
        acc_reg     <= acc_next;
        rdv_reg     <= rdv_next;
        out_rdv_reg <= out_rdv_next;
        out_acc_reg <= out_acc_next;
        out_len_reg <= out_len_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.read_value   = out_rdv_reg;
    assign result.accepted     = out_acc_reg;
    assign result.valid_length = out_len_reg;

    a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(len_reg) <= SLOTS_W)
        else $error("valid length exceeds the slot count");

    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dmxu_pkg::ST_SWEEP) |-> (addr_reg < stop_reg) && (stop_reg <= SLOTS_W))
        else $error("sweep address outside its range");

    a_alloc_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(alloc_reg))
        else $error("allocated flag dropped");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == dmxu_pkg::ST_DONE))
        else $error("result item raised outside the done state");

    a_read_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.rd_en |-> accept && !mem_ctl.wr_en)
        else $error("memory read issued without an accepted item");

endmodule

// ===== rtl/core/dmx_universe_store_htp_merge_core.sv =====
// Top level of the DMX universe store with highest-takes-precedence merge.
//
// One item is worked on at a time through a single-port slot memory with a registered read.
// An item's result enters the output register at the end of its work, so the next item can
// be taken while that result waits. A rejected command or a length-only command goes straight
// to the result; read_slot, merge_slot, load_slot and an in-range set_slot do one read or
// write, then the result; fill of n slots writes those n slots, then the result; blackout,
// and set_slot or fill on a store that is not yet allocated, sweep all SLOTS slots, and the
// memory port writes one slot per cycle. Slot contents are undefined after reset and no
// clearing pass runs; merge_slot and load_slot on a store not yet allocated run no sweep.
module dmx_universe_store_htp_merge_core #(
    parameter int SLOTS = dmxu_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    dmxu_in_if.sink     cmd,
    dmxu_out_if.source  result
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    dmxu_pkg::mem_ctl_t           mem_ctl;
    logic [AW-1:0]                mem_addr;
    logic [dmxu_pkg::VALUE_W-1:0] mem_wdata;
    logic [dmxu_pkg::VALUE_W-1:0] mem_rdata;

    dmxu_ctrl #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .result    (result),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    dmxu_mem #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule
